// ===== rtl/core/complex_arithmetic_unit_top_macros.svh =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit: assertion macros
// Shorthand for the concurrent checks used on the unit's ports.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define CAU_ASSERT_ON(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("item check failed");

// next-cycle implication, off during reset
`define CAU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("item check failed");

// what must follow a reset cycle
`define CAU_ASSERT_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("reset check failed");

`endif

// ===== rtl/core/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Item types, stage records, action and status codes, shared helpers.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int REM_W  = 97;
   localparam int QUO_W  = 33;
   localparam int WIDE_W = 128;

   localparam logic [2:0] ACT_ADD  = 3'd0;
   localparam logic [2:0] ACT_SUB  = 3'd1;
   localparam logic [2:0] ACT_MUL  = 3'd2;
   localparam logic [2:0] ACT_DIV  = 3'd3;
   localparam logic [2:0] ACT_CONJ = 3'd4;
   localparam logic [2:0] ACT_NEG  = 3'd5;
   localparam logic [2:0] ACT_SQM  = 3'd6;
   localparam logic [2:0] ACT_MAG  = 3'd7;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAT  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_re;
      logic signed [31:0] res_im;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic        neg;
      logic [63:0] mag;
   } smag_type;

   typedef struct packed {
      logic [31:0] val;
      logic        sat;
   } clamp_type;

   typedef struct packed {
      logic [2:0]  action;
      logic        n_ar;
      logic        n_ai;
      logic        n_br;
      logic        n_bi;
      logic [31:0] m_ar;
      logic [31:0] m_ai;
      logic [31:0] m_br;
      logic [31:0] m_bi;
      rsp_type     fin;
   } opnd_type;

   typedef struct packed {
      logic [2:0]  action;
      smag_type    p_rr;
      smag_type    p_ii;
      smag_type    p_ri;
      smag_type    p_ir;
      logic [63:0] p_xx;
      logic [63:0] p_yy;
      rsp_type     fin;
   } prod_type;

   typedef struct packed {
      logic [2:0]  action;
      smag_type    s_re;
      smag_type    s_im;
      logic [63:0] s_sq;
      rsp_type     fin;
   } sum_type;

   typedef struct packed {
      logic [2:0]       action;
      logic             den_zero;
      logic             ovf_re;
      logic             ovf_im;
      logic             neg_re;
      logic             neg_im;
      logic [REM_W-1:0] r_re;
      logic [REM_W-1:0] r_im;
      logic [QUO_W-1:0] q_re;
      logic [QUO_W-1:0] q_im;
      logic [63:0]      den;
      logic [63:0]      rem;
      logic [63:0]      root;
      rsp_type          fin;
   } iter_type;

   function automatic logic [31:0] sext_word(logic [31:0] x, int ew);
      logic [31:0] keep;
      logic [31:0] v;
      keep = (ew >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ew) - 64'd1);
      v = x & keep;
      if (x[5'(ew - 1)]) begin
         v = v | ~keep;
      end
      return v;
   endfunction

   function automatic clamp_type clampv(logic neg, logic [64:0] mag, int ew);
      logic [64:0] lim;
      clamp_type   r;
      lim   = (65'd1 << (ew - 1)) - 65'd1;
      r.sat = 1'b0;
      r.val = '0;
      if (!neg) begin
         if (mag > lim) begin
            r.sat = 1'b1;
            r.val = lim[31:0];
         end else begin
            r.val = mag[31:0];
         end
      end else begin
         if (mag > lim + 65'd1) begin
            r.sat = 1'b1;
            r.val = ~lim[31:0];
         end else begin
            r.val = ~mag[31:0] + 32'd1;
         end
      end
      return r;
   endfunction

   // v is a 33-bit two's complement value
   function automatic clamp_type clamp_int(logic [32:0] v, int ew);
      logic [33:0] w;
      logic [33:0] u;
      w = {v[32], v};
      u = v[32] ? (~w + 34'd1) : w;
      return clampv(v[32], {31'd0, u}, ew);
   endfunction

   function automatic smag_type sm_add(smag_type x, smag_type y);
      smag_type r;
      if (x.neg == y.neg) begin
         r.neg = x.neg;
         r.mag = x.mag + y.mag;
      end else if (x.mag >= y.mag) begin
         r.neg = x.neg;
         r.mag = x.mag - y.mag;
      end else begin
         r.neg = y.neg;
         r.mag = y.mag - x.mag;
      end
      return r;
   endfunction

   function automatic smag_type sm_neg(smag_type x);
      smag_type r;
      r     = x;
      r.neg = !x.neg;
      return r;
   endfunction

endpackage

// ===== rtl/core/complex_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Fully pipelined complex ALU on signed fixed point operands: add, subtract,
// multiply, divide, conjugate, negate, squared magnitude and magnitude, with
// saturation and a divide-by-zero status. One item is taken per cycle while
// the pipe does not hold, and every item passes the same stages: two front
// stages for operand decode and the products, two stages to combine and
// round, one stage per quotient bit in the divider / root pipeline (WORD_BITS
// counted at most 32), and the output register. The whole pipe holds while
// a finished result waits and the output is not taken.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cau_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cau_pkg::rsp_type  rsp_data
);
   import cau_pkg::*;

   localparam int EW = (WORD_BITS > 32) ? 32 : ((WORD_BITS < 2) ? 2 : WORD_BITS);
   localparam int EF = (FRAC_BITS > 30) ? 30 : ((FRAC_BITS < 0) ? 0 : FRAC_BITS);

   logic     adv;
   logic     pr_valid;
   prod_type pr_item;
   logic     cb_valid;
   iter_type cb_item;
   logic     it_valid;
   iter_type it_item;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   cau_front #(.EW(EW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_item   (req_data),
      .out_valid (pr_valid),
      .out_item  (pr_item)
   );

   cau_comb #(.EW(EW), .EF(EF)) u_comb (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (pr_valid),
      .in_item   (pr_item),
      .out_valid (cb_valid),
      .out_item  (cb_item)
   );

   cau_iter #(.EW(EW)) u_iter (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (cb_valid),
      .in_item   (cb_item),
      .out_valid (it_valid),
      .out_item  (it_item)
   );

   cau_back #(.EW(EW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (it_valid),
      .in_item   (it_item),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/cau_front.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit: front end
// Operand decode and the short actions, then the six partial products.
// ----------------------------------------------------------------------------
module cau_front #(
   parameter int EW = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  cau_pkg::req_type   in_item,
   output logic               out_valid,
   output cau_pkg::prod_type  out_item
);
   import cau_pkg::*;

   logic        v1_ff;
   logic        v2_ff;
   opnd_type    op_ff;
   opnd_type    op_in;
   prod_type    pr_ff;
   prod_type    pr_in;
   logic [31:0] ar;
   logic [31:0] ai;
   logic [31:0] br;
   logic [31:0] bi;
   clamp_type   c_re;
   clamp_type   c_im;
   logic [31:0] sel_x;
   logic [31:0] sel_y;

   always_comb begin
      ar = sext_word(in_item.a_re, EW);
      ai = sext_word(in_item.a_im, EW);
      br = sext_word(in_item.b_re, EW);
      bi = sext_word(in_item.b_im, EW);
      op_in.action = in_item.action;
      op_in.n_ar   = ar[31];
      op_in.n_ai   = ai[31];
      op_in.n_br   = br[31];
      op_in.n_bi   = bi[31];
      op_in.m_ar   = ar[31] ? (~ar + 32'd1) : ar;
      op_in.m_ai   = ai[31] ? (~ai + 32'd1) : ai;
      op_in.m_br   = br[31] ? (~br + 32'd1) : br;
      op_in.m_bi   = bi[31] ? (~bi + 32'd1) : bi;
      c_re = '0;
      c_im = '0;
      case (in_item.action)
         ACT_ADD: begin
            c_re = clamp_int({ar[31], ar} + {br[31], br}, EW);
            c_im = clamp_int({ai[31], ai} + {bi[31], bi}, EW);
         end
         ACT_SUB: begin
            c_re = clamp_int({ar[31], ar} - {br[31], br}, EW);
            c_im = clamp_int({ai[31], ai} - {bi[31], bi}, EW);
         end
         ACT_CONJ: begin
            c_re.val = ar;
            c_im     = clamp_int(33'd0 - {ai[31], ai}, EW);
         end
         ACT_NEG: begin
            c_re = clamp_int(33'd0 - {ar[31], ar}, EW);
            c_im = clamp_int(33'd0 - {ai[31], ai}, EW);
         end
         default: ;
      endcase
      op_in.fin.res_re = c_re.val;
      op_in.fin.res_im = c_im.val;
      op_in.fin.status = (c_re.sat || c_im.sat) ? ST_SAT : ST_OK;
   end

   always_comb begin
      sel_x = (op_ff.action == ACT_DIV) ? op_ff.m_br : op_ff.m_ar;
      sel_y = (op_ff.action == ACT_DIV) ? op_ff.m_bi : op_ff.m_ai;
      pr_in.action   = op_ff.action;
      pr_in.fin      = op_ff.fin;
      pr_in.p_rr.neg = op_ff.n_ar ^ op_ff.n_br;
      pr_in.p_ii.neg = op_ff.n_ai ^ op_ff.n_bi;
      pr_in.p_ri.neg = op_ff.n_ar ^ op_ff.n_bi;
      pr_in.p_ir.neg = op_ff.n_ai ^ op_ff.n_br;
      pr_in.p_rr.mag = 64'(op_ff.m_ar) * 64'(op_ff.m_br);
      pr_in.p_ii.mag = 64'(op_ff.m_ai) * 64'(op_ff.m_bi);
      pr_in.p_ri.mag = 64'(op_ff.m_ar) * 64'(op_ff.m_bi);
      pr_in.p_ir.mag = 64'(op_ff.m_ai) * 64'(op_ff.m_br);
      pr_in.p_xx     = 64'(sel_x) * 64'(sel_x);
      pr_in.p_yy     = 64'(sel_y) * 64'(sel_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (adv) begin
         op_ff <= op_in;
         pr_ff <= pr_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_item  = pr_ff;

endmodule

// ===== rtl/core/cau_comb.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit: product combine
// Signed sums of products, product rounding, divider and root setup.
// ----------------------------------------------------------------------------
module cau_comb #(
   parameter int EW = 32,
   parameter int EF = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  cau_pkg::prod_type  in_item,
   output logic               out_valid,
   output cau_pkg::iter_type  out_item
);
   import cau_pkg::*;

   localparam logic [64:0] HALF = (EF > 0) ? (65'd1 << (EF > 0 ? EF - 1 : 0)) : 65'd0;
   localparam logic [31:0] LIM  = 32'((64'd1 << (EW - 1)) - 64'd1);

   logic              va_ff;
   logic              vb_ff;
   sum_type           sm_ff;
   sum_type           sm_in;
   iter_type          it_ff;
   iter_type          it_in;
   logic [WIDE_W-1:0] num_re;
   logic [WIDE_W-1:0] num_im;
   logic [WIDE_W-1:0] den_w;
   clamp_type         c_re;
   clamp_type         c_im;

   always_comb begin
      sm_in.action = in_item.action;
      sm_in.fin    = in_item.fin;
      sm_in.s_sq   = in_item.p_xx + in_item.p_yy;
      sm_in.s_re   = '0;
      sm_in.s_im   = '0;
      case (in_item.action)
         ACT_MUL: begin
            sm_in.s_re = sm_add(in_item.p_rr, sm_neg(in_item.p_ii));
            sm_in.s_im = sm_add(in_item.p_ri, in_item.p_ir);
         end
         ACT_DIV: begin
            sm_in.s_re = sm_add(in_item.p_rr, in_item.p_ii);
            sm_in.s_im = sm_add(in_item.p_ir, sm_neg(in_item.p_ri));
         end
         default: ;
      endcase
   end

   always_comb begin
      num_re = WIDE_W'(sm_ff.s_re.mag) << (EF + 1);
      num_im = WIDE_W'(sm_ff.s_im.mag) << (EF + 1);
      den_w  = WIDE_W'(sm_ff.s_sq) << (EW + 1);
      c_re   = '0;
      c_im   = '0;
      it_in.action   = sm_ff.action;
      it_in.fin      = sm_ff.fin;
      it_in.den_zero = (sm_ff.s_sq == 64'd0);
      it_in.ovf_re   = (num_re >= den_w);
      it_in.ovf_im   = (num_im >= den_w);
      it_in.neg_re   = sm_ff.s_re.neg;
      it_in.neg_im   = sm_ff.s_im.neg;
      it_in.r_re     = num_re[REM_W-1:0];
      it_in.r_im     = num_im[REM_W-1:0];
      it_in.q_re     = '0;
      it_in.q_im     = '0;
      it_in.den      = sm_ff.s_sq;
      it_in.rem      = sm_ff.s_sq;
      it_in.root     = '0;
      case (sm_ff.action)
         ACT_MUL: begin
            c_re = clampv(sm_ff.s_re.neg, (65'(sm_ff.s_re.mag) + HALF) >> EF, EW);
            c_im = clampv(sm_ff.s_im.neg, (65'(sm_ff.s_im.mag) + HALF) >> EF, EW);
            it_in.fin.res_re = c_re.val;
            it_in.fin.res_im = c_im.val;
            it_in.fin.status = (c_re.sat || c_im.sat) ? ST_SAT : ST_OK;
         end
         ACT_SQM: begin
            c_re = clampv(1'b0, (65'(sm_ff.s_sq) + HALF) >> EF, EW);
            it_in.fin.res_re = c_re.val;
            it_in.fin.res_im = '0;
            it_in.fin.status = c_re.sat ? ST_SAT : ST_OK;
         end
         ACT_DIV: begin
            if (sm_ff.s_sq == 64'd0) begin
               it_in.fin.res_re = LIM;
               it_in.fin.res_im = LIM;
               it_in.fin.status = ST_DIV0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
      if (adv) begin
         sm_ff <= sm_in;
         it_ff <= it_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_item  = it_ff;

endmodule

// ===== rtl/core/cau_iter.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit: digit pipeline
// One quotient bit per stage for both divide parts, and one root bit per
// stage but the last for the magnitude; other actions ride along.
// ----------------------------------------------------------------------------
module cau_iter #(
   parameter int EW = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  cau_pkg::iter_type  in_item,
   output logic               out_valid,
   output cau_pkg::iter_type  out_item
);
   import cau_pkg::*;

   localparam int NSTG = EW + 1;

   logic [NSTG-1:0] v_ff;
   iter_type        st_ff [NSTG];
   iter_type        st_in [NSTG];
   iter_type        src   [NSTG];

   for (genvar j = 0; j < NSTG; j++) begin : g_stg
      localparam int K = EW - j;

      logic [REM_W-1:0] dsh;
      logic [63:0]      bit_v;
      logic [63:0]      trial;

      if (j == 0) begin : g_head
         assign src[j] = in_item;
      end else begin : g_body
         assign src[j] = st_ff[j-1];
      end

      always_comb begin
         st_in[j] = src[j];
         dsh      = REM_W'(src[j].den) << K;
         bit_v    = 64'd1 << (K > 0 ? 2 * K - 2 : 0);
         trial    = src[j].root + bit_v;
         if (src[j].r_re >= dsh) begin
            st_in[j].r_re    = src[j].r_re - dsh;
            st_in[j].q_re[K] = 1'b1;
         end
         if (src[j].r_im >= dsh) begin
            st_in[j].r_im    = src[j].r_im - dsh;
            st_in[j].q_im[K] = 1'b1;
         end
         if (K > 0) begin
            if (src[j].rem >= trial) begin
               st_in[j].rem  = src[j].rem - trial;
               st_in[j].root = (src[j].root >> 1) + bit_v;
            end else begin
               st_in[j].root = src[j].root >> 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NSTG-2:0], in_valid};
      end
      if (adv) begin
         for (int j = 0; j < NSTG; j++) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   assign out_valid = v_ff[NSTG-1];
   assign out_item  = st_ff[NSTG-1];

endmodule

// ===== rtl/core/cau_back.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit: result stage
// Quotient and root rounding, final saturation, output register.
// ----------------------------------------------------------------------------
module cau_back #(
   parameter int EW = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  cau_pkg::iter_type  in_item,
   output logic               rsp_valid,
   output cau_pkg::rsp_type   rsp_data
);
   import cau_pkg::*;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;
   logic [33:0] qr_re;
   logic [33:0] qr_im;
   logic [64:0] mr_re;
   logic [64:0] mr_im;
   logic [63:0] rt;
   clamp_type   c_re;
   clamp_type   c_im;

   always_comb begin
      qr_re  = ({1'b0, in_item.q_re} + 34'd1) >> 1;
      qr_im  = ({1'b0, in_item.q_im} + 34'd1) >> 1;
      mr_re  = in_item.ovf_re ? '1 : 65'(qr_re);
      mr_im  = in_item.ovf_im ? '1 : 65'(qr_im);
      rt     = in_item.root + 64'(in_item.rem > in_item.root);
      c_re   = '0;
      c_im   = '0;
      rsp_in = in_item.fin;
      case (in_item.action)
         ACT_DIV: begin
            if (!in_item.den_zero) begin
               c_re = clampv(in_item.neg_re, mr_re, EW);
               c_im = clampv(in_item.neg_im, mr_im, EW);
               rsp_in.res_re = c_re.val;
               rsp_in.res_im = c_im.val;
               rsp_in.status = (c_re.sat || c_im.sat) ? ST_SAT : ST_OK;
            end
         end
         ACT_MAG: begin
            c_re = clampv(1'b0, 65'(rt), EW);
            rsp_in.res_re = c_re.val;
            rsp_in.res_im = '0;
            rsp_in.status = c_re.sat ? ST_SAT : ST_OK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= in_valid;
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/cau_checker.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit: port checker
// Concurrent checks on the unit's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_top_macros.svh"

module cau_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cau_pkg::rsp_type  rsp_data
);
   import cau_pkg::*;

   logic rsp_div0;
   logic rsp_wait;

   assign rsp_div0 = rsp_valid && (rsp_data.status == ST_DIV0);
   assign rsp_wait = rsp_valid && !rsp_ready;

   `CAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_data))
   `CAU_ASSERT_ON(a_status_code, clock, reset, rsp_valid, rsp_data.status <= ST_DIV0)
   `CAU_ASSERT_ON(a_div0_value, clock, reset, rsp_div0, rsp_data.res_re == rsp_data.res_im)
   `CAU_ASSERT_ON(a_ready_free, clock, reset, !rsp_valid, req_ready)
   `CAU_ASSERT_RESET(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== dv/complex_arithmetic_unit_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives action/operand items through the valid/ready request channel,
// predicts each result, unless given, with a bit-exact fixed point model and
// checks the response stream in order. Directed extremes come first, then
// random items under several idle/stall mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top_test;
   import cau_pkg::*;

   localparam logic [63:0] WORD_MAX = 64'h7FFF_FFFF;
   localparam logic [63:0] WORD_CAP = 64'h1_0000_0000;
   localparam int          FRAC     = 16;

   typedef struct packed {
      logic        neg;
      logic [63:0] mag;
   } signmag_type;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } vector_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type    results_due[$];
   vector_type vectors[$];
   int         errors = 0;
   int         send_idle = 0;
   int         recv_stall = 0;
   int         holds_asked = 0;
   int         holds_done = 0;
   int         hold_left = 0;

   complex_arithmetic_unit_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("complex_arithmetic_unit_top verification failed");
      $finish;
   end

   function automatic logic [31:0] to_word(logic neg, logic [63:0] mag, inout logic sat);
      if (!neg) begin
         if (mag > WORD_MAX) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
         end
         return mag[31:0];
      end
      if (mag > WORD_MAX + 64'd1) begin
         sat = 1'b1;
         return 32'h8000_0000;
      end
      return 32'(-mag);
   endfunction

   function automatic logic [31:0] clamp_sum(longint v, inout logic sat);
      if (v < 0) return to_word(1'b1, 64'(-v), sat);
      return to_word(1'b0, 64'(v), sat);
   endfunction

   function automatic signmag_type mul_sm(longint a, longint b);
      signmag_type r;
      logic [63:0] ua, ub;
      ua = (a < 0) ? 64'(-a) : 64'(a);
      ub = (b < 0) ? 64'(-b) : 64'(b);
      r.neg = (a < 0) != (b < 0);
      r.mag = ua * ub;
      return r;
   endfunction

   function automatic signmag_type add_sm(signmag_type x, signmag_type y);
      signmag_type r;
      if (x.neg == y.neg) begin
         r.neg = x.neg;
         r.mag = x.mag + y.mag;
      end else if (x.mag >= y.mag) begin
         r.neg = x.neg;
         r.mag = x.mag - y.mag;
      end else begin
         r.neg = y.neg;
         r.mag = y.mag - x.mag;
      end
      return r;
   endfunction

   function automatic signmag_type flip(signmag_type x);
      x.neg = ~x.neg;
      return x;
   endfunction

   function automatic logic [31:0] round_word(signmag_type x, inout logic sat);
      return to_word(x.neg, (x.mag + (64'd1 << (FRAC - 1))) >> FRAC, sat);
   endfunction

   function automatic logic [31:0] divide_word(signmag_type num, logic [63:0] den,
                                              inout logic sat);
      logic [63:0] q, r;
      q = num.mag / den;
      r = num.mag % den;
      if (q > WORD_CAP) q = WORD_CAP;
      for (int i = 0; i < FRAC; i++) begin
         if (q >= WORD_CAP) begin
            q = WORD_CAP;
         end else begin
            q = q << 1;
            if (r >= den - r) begin
               r = r - (den - r);
               q = q | 64'd1;
            end else begin
               r = r << 1;
            end
         end
      end
      if (q < WORD_CAP && r >= den - r) q = q + 64'd1;
      return to_word(num.neg, q, sat);
   endfunction

   function automatic rsp_type complex_result(req_type q);
      rsp_type     o;
      logic        sat;
      longint      ar, ai, br, bi;
      logic [63:0] den, s, root, bitv, rem;
      signmag_type p1, p2, t;
      sat = 1'b0;
      o = '0;
      ar = longint'(q.a_re);
      ai = longint'(q.a_im);
      br = longint'(q.b_re);
      bi = longint'(q.b_im);
      case (q.action)
         ACT_ADD: begin
            o.res_re = clamp_sum(ar + br, sat);
            o.res_im = clamp_sum(ai + bi, sat);
         end
         ACT_SUB: begin
            o.res_re = clamp_sum(ar - br, sat);
            o.res_im = clamp_sum(ai - bi, sat);
         end
         ACT_MUL: begin
            o.res_re = round_word(add_sm(mul_sm(ar, br), flip(mul_sm(ai, bi))), sat);
            o.res_im = round_word(add_sm(mul_sm(ar, bi), mul_sm(ai, br)), sat);
         end
         ACT_DIV: begin
            p1 = mul_sm(br, br);
            p2 = mul_sm(bi, bi);
            den = p1.mag + p2.mag;
            if (den == 64'd0) begin
               o.res_re = 32'h7FFF_FFFF;
               o.res_im = 32'h7FFF_FFFF;
               o.status = ST_DIV0;
               return o;
            end
            o.res_re = divide_word(add_sm(mul_sm(ar, br), mul_sm(ai, bi)), den, sat);
            o.res_im = divide_word(add_sm(mul_sm(ai, br), flip(mul_sm(ar, bi))), den, sat);
         end
         ACT_CONJ: begin
            o.res_re = q.a_re;
            o.res_im = clamp_sum(-ai, sat);
         end
         ACT_NEG: begin
            o.res_re = clamp_sum(-ar, sat);
            o.res_im = clamp_sum(-ai, sat);
         end
         ACT_SQM: begin
            p1 = mul_sm(ar, ar);
            p2 = mul_sm(ai, ai);
            t.neg = 1'b0;
            t.mag = p1.mag + p2.mag;
            o.res_re = round_word(t, sat);
         end
         default: begin
            p1 = mul_sm(ar, ar);
            p2 = mul_sm(ai, ai);
            s = p1.mag + p2.mag;
            root = 64'd0;
            rem = s;
            bitv = 64'd1 << 62;
            while (bitv > s) bitv = bitv >> 2;
            while (bitv != 0) begin
               if (rem >= root + bitv) begin
                  rem = rem - (root + bitv);
                  root = (root >> 1) + bitv;
               end else begin
                  root = root >> 1;
               end
               bitv = bitv >> 2;
            end
            if (s - root * root > root) root = root + 64'd1;
            o.res_re = to_word(1'b0, root, sat);
         end
      endcase
      o.status = sat ? ST_SAT : ST_OK;
      return o;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            report("unexpected item", rsp_data.res_re, 32'h0);
         end else begin
            want = results_due.pop_front();
            if (rsp_data.res_re !== want.res_re) report("res_re", rsp_data.res_re, want.res_re);
            if (rsp_data.res_im !== want.res_im) report("res_im", rsp_data.res_im, want.res_im);
            if (rsp_data.status !== want.status)
               report("status", 32'(rsp_data.status), 32'(want.status));
         end
      end
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_done < holds_asked) begin
         holds_done <= holds_done + 1;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !reset && ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic send(vector_type v);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1'b1;
      req_data <= v.req;
      do @(posedge clock); while (!req_ready);
      results_due.push_back(v.typed ? v.rsp : complex_result(v.req));
   endtask

   task automatic add_vector(logic [2:0] act, logic [31:0] ar, logic [31:0] ai,
                             logic [31:0] br, logic [31:0] bi, bit typed = 0,
                             logic [31:0] rr = 0, logic [31:0] ri = 0,
                             logic [1:0] st = ST_OK);
      vector_type v;
      v.req = '{act, ar, ai, br, bi};
      v.typed = typed;
      v.rsp = '{rr, ri, st};
      vectors.push_back(v);
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(5))
         0, 1: return $urandom;
         2: return $urandom_range(32'h3_FFFF);
         3: return -$urandom_range(32'h3_FFFF);
         4: return $urandom_range(32'h7F_FFFF) ^ {32{$urandom_range(1) == 1}};
         default: begin
            case ($urandom_range(4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0001_0000;
            endcase
         end
      endcase
   endfunction

   task automatic drain();
      int waited;
      waited = 0;
      while (results_due.size() != 0) begin
         @(posedge clock);
         waited++;
         if (waited > 200_000) begin
            $display("complex_arithmetic_unit_top verification failed");
            $finish;
         end
      end
   endtask

   initial begin
      vector_type v;
      int         pct_idle[4];
      int         pct_stall[4];
      pct_idle  = '{0, 59, 0, 24};
      pct_stall = '{0, 0, 59, 24};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_vector(ACT_ADD, 32'h7FFF_FFFF, 0, 1, 0, 1, 32'h7FFF_FFFF, 0, ST_SAT);
      add_vector(ACT_ADD, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                 1, 32'h8000_0000, 32'h8000_0000, ST_SAT);
      add_vector(ACT_SUB, 32'h8000_0000, 0, 1, 0, 1, 32'h8000_0000, 0, ST_SAT);
      add_vector(ACT_SUB, 5, 7, 5, 7, 1, 0, 0, ST_OK);
      add_vector(ACT_MUL, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
      add_vector(ACT_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_vector(ACT_MUL, 32'h0000_8000, 0, 32'h0000_0001, 0);
      add_vector(ACT_DIV, 32'h0001_0000, 1, 0, 0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ST_DIV0);
      add_vector(ACT_DIV, 0, 0, 0, 0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ST_DIV0);
      add_vector(ACT_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hFFFE_0000);
      add_vector(ACT_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1);
      add_vector(ACT_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      add_vector(ACT_CONJ, 1, 32'h8000_0000, 0, 0, 1, 1, 32'h7FFF_FFFF, ST_SAT);
      add_vector(ACT_CONJ, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0,
                 1, 32'h8000_0000, 32'h8000_0001, ST_OK);
      add_vector(ACT_NEG, 32'h8000_0000, 32'h8000_0000, 0, 0,
                 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ST_SAT);
      add_vector(ACT_NEG, 32'h7FFF_FFFF, 0, 0, 0, 1, 32'h8000_0001, 0, ST_OK);
      add_vector(ACT_SQM, 0, 0, 0, 0, 1, 0, 0, ST_OK);
      add_vector(ACT_SQM, 32'h8000_0000, 32'h8000_0000, 0, 0, 1, 32'h7FFF_FFFF, 0, ST_SAT);
      add_vector(ACT_SQM, 32'h0000_0080, 32'hFFFF_FF80, 0, 0);
      add_vector(ACT_MAG, 0, 0, 0, 0, 1, 0, 0, ST_OK);
      add_vector(ACT_MAG, 32'h0003_0000, 32'h0004_0000, 0, 0, 1, 32'h0005_0000, 0, ST_OK);
      add_vector(ACT_MAG, 32'h8000_0000, 32'h8000_0000, 0, 0);
      add_vector(ACT_MAG, 1, 1, 0, 0);
      foreach (vectors[i]) send(vectors[i]);
      req_valid <= 1'b0;
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle = pct_idle[ph];
         recv_stall = pct_stall[ph];
         if (ph == 0) holds_asked = holds_asked + 1;
         for (int n = 0; n < 500; n++) begin
            v.typed = 0;
            v.req.action = 3'($urandom_range(7));
            v.req.a_re = pick_operand();
            v.req.a_im = pick_operand();
            v.req.b_re = pick_operand();
            v.req.b_im = pick_operand();
            if (v.req.action == ACT_DIV && $urandom_range(19) == 0) begin
               v.req.b_re = 32'h0;
               v.req.b_im = 32'h0;
            end
            send(v);
         end
         req_valid <= 1'b0;
         drain();
      end

      repeat (60) @(posedge clock);
      if (errors == 0 && results_due.size() == 0) begin
         $display("complex_arithmetic_unit_top verification clean");
      end else begin
         $display("complex_arithmetic_unit_top verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cau_pkg.sv
rtl/core/cau_front.sv
rtl/core/cau_comb.sv
rtl/core/cau_iter.sv
rtl/core/cau_back.sv
rtl/core/complex_arithmetic_unit_top.sv
rtl/core/cau_checker.sv
dv/complex_arithmetic_unit_top_test.sv
